[sv/prp_pkg.sv]
package prp_pkg;

	// Default build widths
	localparam int COORD_WIDTH_DEF = 16;
	localparam int TRIG_FRAC_DEF   = 16;

	// Fixed point formats of the point and zoom inputs
	localparam int POINT_FRAC = 8;
	localparam int ZOOM_FRAC  = 8;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int ANGLE_W    = 16;
	localparam int NUM_ANGLES = 3;

	// Register indices
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd7;

	// Register reset values
	localparam logic [15:0] ZOOM_RST     = 16'd256;
	localparam logic [11:0] CENTER_X_RST = 12'd960;
	localparam logic [11:0] CENTER_Y_RST = 12'd540;

	// A quarter turn of a binary angle
	localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;

	// Screen placement handed to the transform pipeline
	typedef struct packed {
		logic [15:0]        zoom;
		logic signed [13:0] off_x;
		logic signed [13:0] off_y;
	} prp_view_t;

endpackage

[sv/prp_trig_seq.sv]
module prp_trig_seq import prp_pkg::*; #(
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [ANGLE_W-1:0]               angle [NUM_ANGLES],
	output logic                             busy,
	output logic signed [TRIG_FRAC_BITS+1:0] term [6]
);

	localparam int TW = TRIG_FRAC_BITS + 2;
	localparam int MW = 2 * TW;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_UX   = 4'd1;
	localparam logic [3:0] ST_XX   = 4'd2;
	localparam logic [3:0] ST_X2   = 4'd3;
	localparam logic [3:0] ST_DIV  = 4'd4;
	localparam logic [3:0] ST_TM   = 4'd5;
	localparam logic [3:0] ST_TR   = 4'd6;
	localparam logic [3:0] ST_MM   = 4'd7;
	localparam logic [3:0] ST_MW   = 4'd8;
	localparam logic [3:0] ST_DQ   = 4'd9;

	localparam logic [31:0] RAD_STEP = 32'd102944;
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [32:0] SIN_RND  = 33'(1) << (29 - TRIG_FRAC_BITS);
	localparam logic [32:0] ONE_F    = 33'(1) << TRIG_FRAC_BITS;
	localparam logic signed [MW-1:0] MM_RND = MW'(1) << (TRIG_FRAC_BITS - 1);
	localparam logic [1:0] LAST_DIV  = 2'd3;
	localparam logic [2:0] LAST_TRIG = 3'd5;
	localparam logic [2:0] LAST_MM   = 3'd7;
	localparam logic signed [TW-1:0] TERM_MAX = {1'b0, {(TW-1){1'b1}}};
	localparam logic signed [TW-1:0] TERM_MIN = {1'b1, {(TW-1){1'b0}}};
	localparam logic signed [TW-1:0] TERM_ONE = TW'(1) << TRIG_FRAC_BITS;

	// Rounded-up reciprocals of the odd divisor parts, exact for dividends below 2^31
	localparam logic [31:0] RCP_9  = 32'd3817748708;
	localparam logic [31:0] RCP_21 = 32'd3272356036;
	localparam logic [31:0] RCP_5  = 32'd3435973837;
	localparam logic [31:0] RCP_3  = 32'd2863311531;

	logic [3:0]  state_q;
	logic [2:0]  k_q;
	logic [1:0]  dstep_q;
	logic [2:0]  mstep_q;
	logic        sign_q;
	logic [30:0] x_q;
	logic [31:0] x2_q;
	logic [31:0] div_n_q;
	logic [63:0] mul_p_q;
	logic [31:0] mul_a, mul_b;

	logic signed [TW-1:0] trig_q [6];
	logic signed [TW-1:0] term_q [6];
	logic signed [TW-1:0] sxsy_q;
	logic signed [TW:0]   acc_q;
	logic signed [MW-1:0] mm_p_q;
	logic signed [TW-1:0] mm_a, mm_b;

	logic [ANGLE_W-1:0] ang;
	logic [14:0]        u;
	logic [31:0]        dvd;
	logic [31:0]        rcp;
	logic [31:0]        quo;
	logic [30:0]        t_val;
	logic [31:0]        s_v;
	logic [32:0]        s_rnd, s_full;
	logic [TRIG_FRAC_BITS:0] s_mag;
	logic signed [TW-1:0] trig_val;
	logic signed [MW-1:0] mm_rnd;
	logic signed [TW:0]   mm_r, mm_neg;

	// Trig entries in sequencer order: sx, cx, sy, cy, sz, cz
	logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;
	assign sx = trig_q[0];
	assign cx = trig_q[1];
	assign sy = trig_q[2];
	assign cy = trig_q[3];
	assign sz = trig_q[4];
	assign cz = trig_q[5];

	function automatic logic signed [TW-1:0] sat_term(input logic signed [TW+1:0] v);
		logic [2:0] top;
		top = v[TW+1:TW-1];
		if (&top || ~|top)
			return v[TW-1:0];
		else
			return v[TW+1] ? TERM_MIN : TERM_MAX;
	endfunction

	assign busy = (state_q != ST_IDLE);
	assign term = term_q;

	// Select the angle; odd entries are cosines, a quarter turn ahead
	always_comb begin
		case (k_q[2:1])
			2'd0:    ang = angle[0];
			2'd1:    ang = angle[1];
			default: ang = angle[2];
		endcase
		if (k_q[0])
			ang = ang + QUARTER_TURN;
	end

	// Fold into the first quadrant
	assign u = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};

	// Series divisors 72, 42, 20, 6, innermost first: shift out the power of two,
	// then multiply by the reciprocal of the odd part and keep the top bits
	always_comb begin
		case (dstep_q)
			2'd0: begin
				dvd = {3'b0, div_n_q[31:3]};
				rcp = RCP_9;
				quo = {3'b0, mul_p_q[63:35]};
			end
			2'd1: begin
				dvd = {1'b0, div_n_q[31:1]};
				rcp = RCP_21;
				quo = {4'b0, mul_p_q[63:36]};
			end
			2'd2: begin
				dvd = {2'b0, div_n_q[31:2]};
				rcp = RCP_5;
				quo = {2'b0, mul_p_q[63:34]};
			end
			default: begin
				dvd = {1'b0, div_n_q[31:1]};
				rcp = RCP_3;
				quo = {1'b0, mul_p_q[63:33]};
			end
		endcase
	end

	assign t_val = ONE_Q30 - div_n_q[30:0];

	// Round the series result to the table precision and cap at one
	assign s_v    = mul_p_q[61:30];
	assign s_rnd  = {1'b0, s_v} + SIN_RND;
	assign s_full = s_rnd >> (30 - TRIG_FRAC_BITS);
	assign s_mag  = (s_full > ONE_F) ? ONE_F[TRIG_FRAC_BITS:0] : s_full[TRIG_FRAC_BITS:0];
	assign trig_val = sign_q ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

	// Operands of the series multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_UX: begin
				mul_a = {17'b0, u};
				mul_b = RAD_STEP;
			end
			ST_XX: begin
				mul_a = {1'b0, mul_p_q[30:0]};
				mul_b = {1'b0, mul_p_q[30:0]};
			end
			ST_DIV: begin
				mul_a = dvd;
				mul_b = rcp;
			end
			ST_TM: begin
				mul_a = (dstep_q == LAST_DIV) ? {1'b0, x_q} : x2_q;
				mul_b = {1'b0, t_val};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Operands of the matrix multiplier, one product per step
	always_comb begin
		case (mstep_q)
			3'd0: begin mm_a = sx;     mm_b = sy; end
			3'd1: begin mm_a = cy;     mm_b = cz; end
			3'd2: begin mm_a = cy;     mm_b = sz; end
			3'd3: begin mm_a = sxsy_q; mm_b = cz; end
			3'd4: begin mm_a = cx;     mm_b = sz; end
			3'd5: begin mm_a = cx;     mm_b = cz; end
			3'd6: begin mm_a = sxsy_q; mm_b = sz; end
			default: begin mm_a = sx;  mm_b = cy; end
		endcase
	end

	assign mm_rnd = mm_p_q + MM_RND;
	assign mm_r   = mm_rnd[2*TRIG_FRAC_BITS+2:TRIG_FRAC_BITS];
	assign mm_neg = -mm_r;

	// Multiplier and datapath registers
	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		mm_p_q  <= mm_a * mm_b;
		case (state_q)
			ST_UX:  sign_q <= ang[15];
			ST_XX:  x_q <= mul_p_q[30:0];
			ST_X2: begin
				x2_q    <= mul_p_q[61:30];
				div_n_q <= mul_p_q[61:30];
			end
			ST_DQ:  div_n_q <= quo;
			ST_TR: begin
				if (dstep_q != LAST_DIV)
					div_n_q <= s_v;
				else
					trig_q[k_q] <= trig_val;
			end
			ST_MW: begin
				case (mstep_q)
					3'd0:    sxsy_q <= mm_r[TW-1:0];
					3'd3:    acc_q  <= mm_r;
					3'd5:    acc_q  <= mm_r;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Sequencer control and the stored matrix rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			dstep_q <= '0;
			mstep_q <= '0;
			for (int i = 0; i < 6; i++)
				term_q[i] <= '0;
			term_q[0] <= TERM_ONE;
			term_q[4] <= TERM_ONE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						k_q     <= '0;
						state_q <= ST_UX;
					end
				end
				ST_UX: state_q <= ST_XX;
				ST_XX: state_q <= ST_X2;
				ST_X2: begin
					dstep_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: state_q <= ST_DQ;
				ST_DQ:  state_q <= ST_TM;
				ST_TM:  state_q <= ST_TR;
				ST_TR: begin
					if (dstep_q != LAST_DIV) begin
						dstep_q <= dstep_q + 2'd1;
						state_q <= ST_DIV;
					end else if (k_q == LAST_TRIG) begin
						mstep_q <= '0;
						state_q <= ST_MM;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= ST_UX;
					end
				end
				ST_MM: state_q <= ST_MW;
				ST_MW: begin
					// Only the first two rows reach the screen
					case (mstep_q)
						3'd1: term_q[0] <= mm_r[TW-1:0];
						3'd2: begin
							term_q[1] <= mm_neg[TW-1:0];
							term_q[2] <= sy;
						end
						3'd4: term_q[3] <= sat_term((TW+2)'(acc_q) + (TW+2)'(mm_r));
						3'd6: term_q[4] <= sat_term((TW+2)'(acc_q) - (TW+2)'(mm_r));
						3'd7: term_q[5] <= mm_neg[TW-1:0];
						default: ;
					endcase
					if (mstep_q == LAST_MM) begin
						state_q <= ST_IDLE;
					end else begin
						mstep_q <= mstep_q + 3'd1;
						state_q <= ST_MM;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/prp_xform.sv]
module prp_xform import prp_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	output logic                             ready,
	input  logic signed [COORD_WIDTH-1:0]    px,
	input  logic signed [COORD_WIDTH-1:0]    py,
	input  logic signed [COORD_WIDTH-1:0]    pz,
	input  logic signed [TRIG_FRAC_BITS+1:0] term [6],
	input  prp_view_t                        view,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic signed [COORD_WIDTH-1:0]    res_x,
	output logic signed [COORD_WIDTH-1:0]    res_y
);

	localparam int CW  = COORD_WIDTH;
	localparam int TW  = TRIG_FRAC_BITS + 2;
	localparam int PW  = TW + CW;
	localparam int SW  = PW + 2;
	localparam int DW  = CW + 4;
	localparam int ZW  = DW + 17;
	localparam int SH  = POINT_FRAC + ZOOM_FRAC;
	localparam int OW  = 14 + SH;
	localparam int AW  = ((ZW > OW) ? ZW : OW) + 1;
	localparam int VW  = AW - SH;

	localparam logic signed [SW-1:0] DOT_RND = SW'(1) << (TRIG_FRAC_BITS - 1);
	localparam logic signed [AW-1:0] PIX_RND = AW'(1) << (SH - 1);
	localparam logic signed [CW-1:0] RES_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] RES_MIN = {1'b1, {(CW-1){1'b0}}};

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	logic signed [PW-1:0] prod_s1 [2][3];
	logic signed [SW-1:0] sum_s2  [2];
	logic signed [DW-1:0] dr_s3   [2];
	logic signed [ZW-1:0] zp_s4   [2];
	logic signed [AW-1:0] acc_s5  [2];
	logic signed [CW-1:0] res_s6  [2];

	logic signed [CW-1:0] pt  [3];
	logic signed [13:0]   off [2];
	logic signed [SW-1:0] dot_rnd [2];
	logic [VW-1:0]        pix [2];

	assign pt[0]  = px;
	assign pt[1]  = py;
	assign pt[2]  = pz;
	assign off[0] = view.off_x;
	assign off[1] = view.off_y;

	// A stage advances when it is empty or the next one advances
	assign en6 = ~v_s6 | res_ready;
	assign en5 = ~v_s5 | en6;
	assign en4 = ~v_s4 | en5;
	assign en3 = ~v_s3 | en4;
	assign en2 = ~v_s2 | en3;
	assign en1 = ~v_s1 | en2;
	assign ready = en1;

	assign res_valid = v_s6;
	assign res_x     = res_s6[0];
	assign res_y     = res_s6[1];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			dot_rnd[l] = sum_s2[l] + DOT_RND;
			pix[l]     = acc_s5[l][AW-1:SH];
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= take;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Two lanes: screen x from row 0, screen y from row 1
	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			// Row products
			if (en1)
				for (int j = 0; j < 3; j++)
					prod_s1[l][j] <= term[3*l+j] * pt[j];
			// Dot product
			if (en2)
				sum_s2[l] <= SW'(prod_s1[l][0]) + SW'(prod_s1[l][1]) + SW'(prod_s1[l][2]);
			// Drop the matrix fraction, rounding half up
			if (en3)
				dr_s3[l] <= dot_rnd[l][TRIG_FRAC_BITS+DW-1:TRIG_FRAC_BITS];
			// Apply the zoom
			if (en4)
				zp_s4[l] <= dr_s3[l] * $signed({1'b0, view.zoom});
			// Add the screen offset and the rounding half
			if (en5)
				acc_s5[l] <= AW'(zp_s4[l]) + AW'($signed({off[l], {SH{1'b0}}})) + PIX_RND;
			// Clamp to the output range
			if (en6) begin
				if (&pix[l][VW-1:CW-1] || ~|pix[l][VW-1:CW-1])
					res_s6[l] <= pix[l][CW-1:0];
				else
					res_s6[l] <= pix[l][VW-1] ? RES_MIN : RES_MAX;
			end
		end
	end

endmodule

[sv/point_rotate_project_core.sv]
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_ready    point_x, point_y, point_z
// out      out        out_valid / out_ready  screen_x, screen_y
//
// One point per cycle while the output is not stalled and no rebuild runs; a point
// passes the registered stages products, dot sum, round, zoom, offset and clamp.
// Each configuration write rebuilds the rotation rows through one shared
// series multiplier, dividing by the series constants with reciprocal
// products; while it runs, in_ready and cfg_ready stay low.
// Reset loads the register defaults and an identity rotation; no sweep.
// An output stall freezes only the stages behind a full one; bubbles close up.
module point_rotate_project_core import prp_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] screen_x,
	output logic signed [COORD_WIDTH-1:0] screen_y
);

	logic [ANGLE_W-1:0] angle_q [NUM_ANGLES];
	logic [15:0]        zoom_q;
	logic signed [12:0] shift_x_q;
	logic signed [12:0] shift_y_q;
	logic [11:0]        center_x_q;
	logic [11:0]        center_y_q;

	logic                             busy;
	logic                             cfg_take;
	logic                             xf_ready;
	logic signed [TRIG_FRAC_BITS+1:0] term [6];
	prp_view_t                        view;

	assign cfg_ready = ~busy;
	assign cfg_take  = cfg_valid & cfg_ready;
	assign in_ready  = xf_ready & ~busy;

	// Fold centre and shift into one offset per axis
	assign view.zoom  = zoom_q;
	assign view.off_x = 14'($signed({1'b0, center_x_q})) - 14'(shift_x_q);
	assign view.off_y = 14'($signed({1'b0, center_y_q})) + 14'(shift_y_q);

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ANGLES; i++)
				angle_q[i] <= '0;
			zoom_q     <= ZOOM_RST;
			shift_x_q  <= '0;
			shift_y_q  <= '0;
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
		end else if (cfg_take) begin
			case (cfg_index)
				REG_ANGLE_X:  angle_q[0] <= cfg_data;
				REG_ANGLE_Y:  angle_q[1] <= cfg_data;
				REG_ANGLE_Z:  angle_q[2] <= cfg_data;
				REG_ZOOM:     zoom_q     <= cfg_data;
				REG_SHIFT_X:  shift_x_q  <= cfg_data[12:0];
				REG_SHIFT_Y:  shift_y_q  <= cfg_data[12:0];
				REG_CENTER_X: center_x_q <= cfg_data[11:0];
				REG_CENTER_Y: center_y_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	prp_trig_seq #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_take),
		.angle  (angle_q),
		.busy   (busy),
		.term   (term)
	);

	prp_xform #(
		.COORD_WIDTH    (COORD_WIDTH),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS)
	) u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_valid & in_ready),
		.ready     (xf_ready),
		.px        (point_x),
		.py        (point_y),
		.pz        (point_z),
		.term      (term),
		.view      (view),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res_x     (screen_x),
		.res_y     (screen_y)
	);

endmodule

[tb/point_rotate_project_core_tb.sv]
`timescale 1ns / 100ps

module point_rotate_project_core_tb;
	import prp_pkg::*;

	localparam int COORD_W    = COORD_WIDTH_DEF;
	localparam int TRIG_FRAC  = TRIG_FRAC_DEF;
	localparam int TERM_W     = TRIG_FRAC + 2;
	localparam int SCREEN_SH  = POINT_FRAC + ZOOM_FRAC;
	localparam longint unsigned Q30_ONE = 64'd1 << 30;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_req_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
	} screen_pos_t;

	logic                          clk;
	logic                          arst_n    = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [CFG_DATA_W-1:0]         cfg_data  = '0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic signed [COORD_W-1:0]     point_x   = '0;
	logic signed [COORD_W-1:0]     point_y   = '0;
	logic signed [COORD_W-1:0]     point_z   = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [COORD_W-1:0]     screen_x;
	logic signed [COORD_W-1:0]     screen_y;

	// Predictor state: register copies and the nine rotation terms
	logic [CFG_DATA_W-1:0] view_reg [8];
	longint                rot_term [9];

	point_req_t  point_q [$];
	reg_write_t  reg_write_q [$];
	screen_pos_t screen_q [$];

	int   fail_count      = 0;
	int   accepted_points = 0;
	int   hold_mark       = 0;
	logic hold_off        = 1'b0;

	int   burst_left = 8;
	int   gap_left   = 0;
	int   stall_mode = 0;
	int   mode_left  = 64;

	point_rotate_project_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.screen_x  (screen_x),
		.screen_y  (screen_y)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Fixed-point helpers: round half up, then clamp to a signed width
	function automatic longint round_half_up(longint v, int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clamp_signed(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -(longint'(1) <<< (w - 1));
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// First-quadrant sine from a truncated Taylor series in Q30
	function automatic longint quarter_sine(longint unsigned u);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint          r;
		x  = u * 64'd102944;
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 64'd72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		r  = longint'((s + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC));
		if (r > (longint'(1) <<< TRIG_FRAC))
			r = longint'(1) <<< TRIG_FRAC;
		return r;
	endfunction

	// Fold a binary angle into the first quadrant and restore the sign
	function automatic longint sine_of(logic [ANGLE_W-1:0] a);
		longint v;
		if (a[14])
			v = quarter_sine(64'(QUARTER_TURN) - 64'(a[13:0]));
		else
			v = quarter_sine(64'(a[13:0]));
		return a[15] ? -v : v;
	endfunction

	function automatic longint mul_trig(longint a, longint b);
		return round_half_up(a * b, TRIG_FRAC);
	endfunction

	// Rebuild R = Rx * Ry * Rz from the three angle registers
	function automatic void rebuild_rotation();
		longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
		longint t [9];
		sx = sine_of(view_reg[REG_ANGLE_X]);
		cx = sine_of(view_reg[REG_ANGLE_X] + QUARTER_TURN);
		sy = sine_of(view_reg[REG_ANGLE_Y]);
		cy = sine_of(view_reg[REG_ANGLE_Y] + QUARTER_TURN);
		sz = sine_of(view_reg[REG_ANGLE_Z]);
		cz = sine_of(view_reg[REG_ANGLE_Z] + QUARTER_TURN);
		sxsy = mul_trig(sx, sy);
		cxsy = mul_trig(cx, sy);
		t[0] = mul_trig(cy, cz);
		t[1] = -mul_trig(cy, sz);
		t[2] = sy;
		t[3] = mul_trig(sxsy, cz) + mul_trig(cx, sz);
		t[4] = mul_trig(cx, cz) - mul_trig(sxsy, sz);
		t[5] = -mul_trig(sx, cy);
		t[6] = mul_trig(sx, sz) - mul_trig(cxsy, cz);
		t[7] = mul_trig(cxsy, sz) + mul_trig(sx, cz);
		t[8] = mul_trig(cx, cy);
		for (int i = 0; i < 9; i++)
			rot_term[i] = clamp_signed(t[i], TERM_W);
	endfunction

	// Mask a write to its register width, then recompute the rotation
	function automatic void write_view_reg(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		int w;
		case (idx)
			REG_SHIFT_X, REG_SHIFT_Y:   w = 13;
			REG_CENTER_X, REG_CENTER_Y: w = 12;
			default:                    w = 16;
		endcase
		view_reg[idx] = data & 16'((17'd1 << w) - 17'd1);
		rebuild_rotation();
	endfunction

	// Rotate, keep x and y, zoom, offset, round and clamp to the screen
	function automatic screen_pos_t project_point(logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
		longint px, py, pz, dx, dy, zoom, shx, shy, cxp, cyp, ox, oy;
		screen_pos_t res;
		px   = longint'(x);
		py   = longint'(y);
		pz   = longint'(z);
		zoom = longint'(view_reg[REG_ZOOM]);
		shx  = longint'($signed(view_reg[REG_SHIFT_X][12:0]));
		shy  = longint'($signed(view_reg[REG_SHIFT_Y][12:0]));
		cxp  = longint'(view_reg[REG_CENTER_X]);
		cyp  = longint'(view_reg[REG_CENTER_Y]);
		dx = round_half_up(rot_term[0] * px + rot_term[1] * py + rot_term[2] * pz,
			TRIG_FRAC);
		dy = round_half_up(rot_term[3] * px + rot_term[4] * py + rot_term[5] * pz,
			TRIG_FRAC);
		ox = round_half_up(dx * zoom + ((cxp - shx) <<< SCREEN_SH), SCREEN_SH);
		oy = round_half_up(dy * zoom + ((cyp + shy) <<< SCREEN_SH), SCREEN_SH);
		ox = clamp_signed(ox, COORD_W);
		oy = clamp_signed(oy, COORD_W);
		res.sx = ox[COORD_W-1:0];
		res.sy = oy[COORD_W-1:0];
		return res;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0:       v = 32'h7FFF;
			1:       v = 32'h8000;
			2, 3:    v = $urandom_range(0, 2047) - 32'd1024;
			default: v = $urandom;
		endcase
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(logic [CFG_IDX_W-1:0] idx);
		logic [31:0] v;
		v = $urandom;
		case (idx)
			REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z:
				if ($urandom_range(0, 1))
					v = ($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 32'd1;
			REG_ZOOM:
				if ($urandom_range(0, 1))
					v = $urandom_range(0, 768);
			default: ;
		endcase
		return v[CFG_DATA_W-1:0];
	endfunction

	task automatic push_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
			logic [COORD_W-1:0] z);
		point_req_t p;
		p.x = x;
		p.y = y;
		p.z = z;
		point_q.insert(point_q.size(), p);
	endtask

	task automatic push_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		reg_write_t w;
		w.idx  = idx;
		w.data = data;
		reg_write_q.insert(reg_write_q.size(), w);
	endtask

	// Wait until every request is taken and every result has come back
	task automatic settle();
		while (point_q.size() != 0 || in_valid || reg_write_q.size() != 0 || cfg_valid
				|| screen_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic note_fault(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// Offer points in bursts with random gaps between them
	always @(posedge clk or negedge arst_n) begin : point_driver
		point_req_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0 || point_q.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left != 0)
					gap_left <= gap_left - 1;
			end else begin
				p = point_q.pop_front();
				point_x  <= p.x;
				point_y  <= p.y;
				point_z  <= p.z;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Present register writes one after another
	always @(posedge clk or negedge arst_n) begin : reg_write_driver
		reg_write_t w;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else if (!cfg_valid || cfg_ready) begin
			if (reg_write_q.size() != 0) begin
				w = reg_write_q.pop_front();
				cfg_index <= w.idx;
				cfg_data  <= w.data;
				cfg_valid <= 1'b1;
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	// Stall the output in changing patterns; hold off fully on request
	always @(posedge clk or negedge arst_n) begin : screen_sink
		logic ready_next;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left  <= $urandom_range(16, 128);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0:       ready_next = 1'b1;
				1:       ready_next = ($urandom_range(0, 3) != 0);
				2:       ready_next = ($urandom_range(0, 3) == 0);
				default: ready_next = ~out_ready;
			endcase
			out_ready <= ready_next && !hold_off;
		end
	end

	// Track accepted requests and check each result against the oldest prediction
	always @(posedge clk) begin : screen_check
		screen_pos_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				write_view_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				screen_q.insert(screen_q.size(), project_point(point_x, point_y, point_z));
				accepted_points++;
			end
			if (out_valid && out_ready) begin
				if (screen_q.size() == 0) begin
					note_fault($sformatf("result (%0d,%0d) with nothing outstanding",
						screen_x, screen_y));
				end else begin
					want = screen_q.pop_front();
					if (want.sx !== screen_x || want.sy !== screen_y)
						note_fault($sformatf("screen mismatch: expected (%0d,%0d) got (%0d,%0d)",
							want.sx, want.sy, screen_x, screen_y));
				end
			end
		end
	end

	// Block the output for a long stretch so the pipeline backs up
	initial begin : output_squeeze
		while (hold_mark == 0 || accepted_points < hold_mark)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin : run_limit
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int n;
		for (int i = 0; i < 8; i++)
			view_reg[i] = '0;
		view_reg[REG_ZOOM]     = ZOOM_RST;
		view_reg[REG_CENTER_X] = 16'(CENTER_X_RST);
		view_reg[REG_CENTER_Y] = 16'(CENTER_Y_RST);
		for (int i = 0; i < 9; i++)
			rot_term[i] = (i % 4 == 0) ? (longint'(1) <<< TRIG_FRAC) : 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset view: field extremes, half-pixel rounding both ways, bit patterns
		push_point(16'h0000, 16'h0000, 16'h0000);
		push_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
		push_point(16'h8000, 16'h8000, 16'h8000);
		push_point(16'h7FFF, 16'h8000, 16'h0000);
		push_point(16'h8000, 16'h7FFF, 16'hFFFF);
		push_point(16'd128, -16'sd128, 16'h0000);
		push_point(-16'sd128, 16'd128, 16'h0000);
		push_point(16'd384, -16'sd384, 16'd5);
		push_point(16'd127, 16'd129, 16'h0000);
		push_point(-16'sd129, -16'sd127, 16'h0000);
		push_point(16'h5555, 16'hAAAA, 16'h5555);
		push_point(16'hAAAA, 16'h5555, 16'hAAAA);
		push_point(16'd256, 16'd512, -16'sd256);
		push_point(16'hFFFF, 16'h0001, 16'hFFFF);

		// Quadrant angles, full zoom, extreme offsets: drive into saturation
		settle();
		push_reg(REG_ANGLE_X, QUARTER_TURN);
		push_reg(REG_ANGLE_Y, QUARTER_TURN << 1);
		push_reg(REG_ANGLE_Z, QUARTER_TURN * 3);
		push_reg(REG_ZOOM, 16'hFFFF);
		push_reg(REG_SHIFT_X, 16'h1000);
		push_reg(REG_SHIFT_Y, 16'h0FFF);
		push_reg(REG_CENTER_X, 16'h0FFF);
		push_reg(REG_CENTER_Y, 16'h0000);
		settle();
		push_point(16'h7FFF, 16'h0000, 16'h0000);
		push_point(16'h8000, 16'h0000, 16'h0000);
		push_point(16'h0000, 16'h7FFF, 16'h0000);
		push_point(16'h0000, 16'h0000, 16'h8000);
		push_point(16'h0001, 16'h0001, 16'h0001);

		// Near-full-turn and tiny angles, zero zoom, opposite offset extremes
		settle();
		push_reg(REG_ANGLE_X, 16'hFFFF);
		push_reg(REG_ANGLE_Y, 16'h0001);
		push_reg(REG_ANGLE_Z, QUARTER_TURN >> 1);
		push_reg(REG_ZOOM, 16'h0000);
		push_reg(REG_SHIFT_X, 16'h0FFF);
		push_reg(REG_SHIFT_Y, 16'h1000);
		push_reg(REG_CENTER_X, 16'h0000);
		push_reg(REG_CENTER_Y, 16'h0FFF);
		settle();
		push_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
		push_point(16'h8000, 16'h8000, 16'h8000);
		push_point(16'd100, -16'sd100, 16'd7);
		push_point(16'h0000, 16'h0000, 16'h0000);
		push_point(16'hFFFF, 16'hFFFF, 16'hFFFF);

		// Random views, each followed by a stream of random points
		for (int phase = 0; phase < 8; phase++) begin
			settle();
			for (int r = 0; r < 8; r++)
				if (phase == 0 || $urandom_range(0, 1))
					push_reg(CFG_IDX_W'(r), pick_reg_value(CFG_IDX_W'(r)));
			settle();
			if (phase == 1)
				hold_mark = accepted_points + 10;
			n = $urandom_range(60, 76);
			repeat (n) push_point(pick_coord(), pick_coord(), pick_coord());
		end

		settle();
		repeat (20) @(posedge clk);
		fail_count += screen_q.size();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
